// ===== design/bbpa_pkg.sv =====
`timescale 1ns / 1ps

package bbpa_pkg;

    localparam int ADDR_W          = 48;
    localparam int SHIFT_W         = 5;
    localparam int BCOUNT_W        = 9;
    localparam int WORD_BITS       = 32;
    localparam int WORD_IDX_W      = 5;
    localparam int APB_DATA_W      = 64;
    localparam int APB_ADDR_W      = 5;
    localparam int REG_SEL_LSB     = 3;
    localparam int MAX_BUFFERS_DEF = 256;

    localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = 5'd20;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd10;

    typedef enum logic [1:0] {
        ST_OK,
        ST_EMPTY,
        ST_OFF,
        ST_BADFREE
    } t_status;

    typedef enum logic [1:0] {
        REG_POOL_BASE,
        REG_BUFFER_SHIFT,
        REG_BUFFER_COUNT,
        REG_ENABLED
    } t_reg_idx;

    typedef enum logic {
        ACT_ALLOC,
        ACT_FREE
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FMAP,
        S_FMOD,
        S_SCAN,
        S_ADDR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]   pool_base;
        logic [SHIFT_W-1:0]  shift;
        logic [BCOUNT_W-1:0] buffer_count;
        logic                enabled;
        logic                start;
    } t_cfg;

endpackage

// ===== design/bbpa_in_if.sv =====
`timescale 1ns / 1ps

interface bbpa_in_if;
    import bbpa_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, output action, output free_address, input ready);
    modport sink (input valid, input action, input free_address, output ready);
endinterface

// ===== design/bbpa_out_if.sv =====
`timescale 1ns / 1ps

interface bbpa_out_if;
    import bbpa_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;
    logic [1:0]        status;

    modport source (output valid, output address, output status, input ready);
    modport sink (input valid, input address, input status, output ready);
endinterface

// ===== design/bbpa_cfg.sv =====
`timescale 1ns / 1ps

module bbpa_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bbpa_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bbpa_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bbpa_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output bbpa_pkg::t_cfg                      o_cfg
);
    import bbpa_pkg::*;

    logic [ADDR_W-1:0]   r_pool_base;
    logic [SHIFT_W-1:0]  r_buffer_shift;
    logic [BCOUNT_W-1:0] r_buffer_count;
    logic                r_enabled;
    logic                w_wr;
    t_reg_idx            w_sel;

    assign w_sel  = t_reg_idx'(paddr[APB_ADDR_W-1:REG_SEL_LSB]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base    <= '0;
            r_buffer_shift <= SHIFT_RESET;
            r_buffer_count <= '0;
            r_enabled      <= 1'b0;
        end else if (w_wr) begin
            case (w_sel)
                REG_POOL_BASE:    r_pool_base    <= pwdata[ADDR_W-1:0];
                REG_BUFFER_SHIFT: r_buffer_shift <= pwdata[SHIFT_W-1:0];
                REG_BUFFER_COUNT: r_buffer_count <= pwdata[BCOUNT_W-1:0];
                REG_ENABLED:      r_enabled      <= pwdata[0];
                default:          r_enabled      <= r_enabled;
            endcase
        end
    end

    always_comb begin
        case (w_sel)
            REG_POOL_BASE:    prdata = APB_DATA_W'(r_pool_base);
            REG_BUFFER_SHIFT: prdata = APB_DATA_W'(r_buffer_shift);
            REG_BUFFER_COUNT: prdata = APB_DATA_W'(r_buffer_count);
            REG_ENABLED:      prdata = APB_DATA_W'(r_enabled);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.pool_base    = r_pool_base;
    assign o_cfg.shift        = (r_buffer_shift > SHIFT_LIMIT) ? SHIFT_LIMIT : r_buffer_shift;
    assign o_cfg.buffer_count = r_buffer_count;
    assign o_cfg.enabled      = r_enabled;
    assign o_cfg.start        = w_wr && (w_sel == REG_ENABLED) && pwdata[0] && !r_enabled;

endmodule

// ===== design/bbpa_core.sv =====
`timescale 1ns / 1ps

module bbpa_core #(
    parameter int MAX_BUFFERS = bbpa_pkg::MAX_BUFFERS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bbpa_pkg::t_cfg i_cfg,
    bbpa_in_if.sink        i_req,
    bbpa_out_if.source     o_rsp
);
    import bbpa_pkg::*;

    localparam int WORDS = (MAX_BUFFERS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IDX_W = WA_W + WORD_IDX_W;
    localparam int CW    = IDX_W + 1;
    localparam int CNT_W = $clog2(MAX_BUFFERS + 1);
    localparam int LW    = (CNT_W > BCOUNT_W) ? CNT_W : BCOUNT_W;
    localparam logic [LW-1:0] MAX_L = LW'(MAX_BUFFERS);

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    t_state               r_state, n_state;
    logic [WORDS-1:0]     r_valid, n_valid;
    logic [CNT_W-1:0]     r_free_total, n_free_total;
    logic                 r_out_valid, n_out_valid;
    logic [ADDR_W:0]      r_diff, n_diff;
    logic [WA_W-1:0]      r_word, n_word;
    logic [WORD_IDX_W-1:0] r_bit, n_bit;
    t_status              r_status, n_status;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [ADDR_W-1:0]    r_out_addr, n_out_addr;
    t_status              r_out_status, n_out_status;

    logic                 w_rd_en;
    logic [WA_W-1:0]      w_rd_addr;
    logic                 w_wr_en;
    logic [WORD_BITS-1:0] w_wr_data;

    logic [LW-1:0]        w_cnt_l;
    logic [CW-1:0]        w_count;
    logic [WORD_BITS-1:0] w_word;
    logic [CW-1:0]        w_base;
    logic [CW-1:0]        w_rem;
    logic [CW-1:0]        w_next_base;
    logic [WORD_BITS-1:0] w_elig;
    logic [WORD_BITS-1:0] w_cand;
    logic                 w_found;
    logic [WORD_IDX_W-1:0] w_pos;
    logic                 w_more;
    logic [ADDR_W-1:0]    w_off;
    logic                 w_free_ok;
    logic [ADDR_W-1:0]    w_alloc_addr;
    logic                 w_out_free;

    assign w_cnt_l = (LW'(i_cfg.buffer_count) > MAX_L) ? MAX_L : LW'(i_cfg.buffer_count);
    assign w_count = CW'(w_cnt_l);

    assign w_word      = r_valid[r_word] ? r_rdata : '0;
    assign w_base      = CW'({r_word, {WORD_IDX_W{1'b0}}});
    assign w_rem       = (w_count > w_base) ? (w_count - w_base) : '0;
    assign w_next_base = w_base + CW'(WORD_BITS);
    assign w_more      = (w_next_base < w_count);

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            w_elig[j] = (CW'(j) < w_rem);
        end
    end

    assign w_cand  = ~w_word & w_elig;
    assign w_found = |w_cand;

    always_comb begin
        w_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (w_cand[j]) begin
                w_pos = WORD_IDX_W'(j);
            end
        end
    end

    assign w_off     = r_diff[ADDR_W-1:0] >> i_cfg.shift;
    assign w_free_ok = !r_diff[ADDR_W] && (w_off[ADDR_W-1:CW] == '0)
                       && (w_off[CW-1:0] < w_count);

    assign w_alloc_addr = i_cfg.pool_base + (ADDR_W'({r_word, r_bit}) << i_cfg.shift);
    assign w_out_free   = !r_out_valid || o_rsp.ready;

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.address = r_out_addr;
    assign o_rsp.status = r_out_status;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (!i_cfg.enabled) begin
                        n_state = S_DONE;
                    end else if (t_action'(i_req.action) == ACT_FREE) begin
                        n_state = S_FMAP;
                    end else if (r_free_total == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_FMAP: begin
                n_state = w_free_ok ? S_FMOD : S_DONE;
            end
            S_FMOD: begin
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (w_found) begin
                    n_state = S_ADDR;
                end else if (!w_more) begin
                    n_state = S_DONE;
                end
            end
            S_ADDR: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_valid      = r_valid;
        n_free_total = r_free_total;
        n_diff       = r_diff;
        n_word       = r_word;
        n_bit        = r_bit;
        n_status     = r_status;
        n_addr       = r_addr;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_word;
        w_wr_en      = 1'b0;
        w_wr_data    = w_word;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_diff   = {1'b0, i_req.free_address} - {1'b0, i_cfg.pool_base};
                    n_addr   = '0;
                    n_status = ST_OK;
                    if (!i_cfg.enabled) begin
                        n_status = ST_OFF;
                    end else if (t_action'(i_req.action) == ACT_ALLOC) begin
                        if (r_free_total == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_word    = '0;
                            w_rd_en   = 1'b1;
                            w_rd_addr = '0;
                        end
                    end
                end
            end
            S_FMAP: begin
                if (w_free_ok) begin
                    n_word    = w_off[IDX_W-1:WORD_IDX_W];
                    n_bit     = w_off[WORD_IDX_W-1:0];
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_off[IDX_W-1:WORD_IDX_W];
                end else begin
                    n_status = ST_BADFREE;
                end
            end
            S_FMOD: begin
                if (w_word[r_bit]) begin
                    w_wr_en          = 1'b1;
                    w_wr_data        = w_word & ~(WORD_BITS'(1) << r_bit);
                    n_valid[r_word]  = 1'b1;
                    n_free_total     = r_free_total + CNT_W'(1);
                end else begin
                    n_status = ST_BADFREE;
                end
            end
            S_SCAN: begin
                if (w_found) begin
                    w_wr_en          = 1'b1;
                    w_wr_data        = w_word | (WORD_BITS'(1) << w_pos);
                    n_valid[r_word]  = 1'b1;
                    n_free_total     = r_free_total - CNT_W'(1);
                    n_bit            = w_pos;
                end else if (w_more) begin
                    n_word    = r_word + WA_W'(1);
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_word + WA_W'(1);
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            S_ADDR: begin
                n_addr = w_alloc_addr;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_addr;
                    n_out_status = r_status;
                end
            end
            default: begin
                n_status = r_status;
            end
        endcase
        if (i_cfg.start) begin
            n_valid      = '0;
            n_free_total = CNT_W'(w_cnt_l);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_free_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_free_total <= n_free_total;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff       <= n_diff;
        r_word       <= n_word;
        r_bit        <= n_bit;
        r_status     <= n_status;
        r_addr       <= n_addr;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_word] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

endmodule

// ===== design/bitmap_buffer_pool_allocator.sv =====
`timescale 1ns / 1ps

// Fixed-size buffer pool allocator. Each request on i_req is either an allocate, which
// returns the address of the lowest free buffer, or a free, which releases the buffer that
// holds the given address; each yields exactly one transfer on o_rsp with an address and a
// status (ok, no buffer free, pool not enabled, bad free address). The pool base, buffer
// shift, buffer count and enable registers sit at byte addresses 0, 8, 16 and 24 of the
// 64-bit APB port; the user must write them only while no request is in flight (the block
// does not enforce this). Writing 1 to the enable register while it reads 0 marks every
// buffer free at once, with no clearing pass. The usage bitmap lives in a memory of
// 32-bit words; an allocate that finds a clear bit and a free of a used buffer read,
// modify and write back one word. A request to a disabled pool, or an allocate with a
// zero free count, goes from idle straight to done. A free passes the map and modify
// states, skipping modify when its address lies outside the pool. An allocate scans the
// bitmap words for a clear bit below the buffer count. A new request is taken while the
// previous result still waits on o_rsp; the next result waits until that one is taken.

module bitmap_buffer_pool_allocator #(
    parameter int MAX_BUFFERS = bbpa_pkg::MAX_BUFFERS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bbpa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bbpa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bbpa_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    bbpa_in_if.sink                         i_req,
    bbpa_out_if.source                      o_rsp
);
    import bbpa_pkg::*;

    t_cfg w_cfg;

    bbpa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bbpa_core #(
        .MAX_BUFFERS (MAX_BUFFERS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== tb/sv/pool_reply_checker.sv =====
`timescale 1ns / 1ps

module pool_reply_checker
    import bbpa_pkg::*;
#(
    parameter int MAX_BUFFERS = MAX_BUFFERS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    bbpa_in_if                    req,
    bbpa_out_if                   rsp,
    output int                    o_mismatches,
    output int                    o_awaited
);

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        t_status           status;
    } pool_reply_t;

    logic [ADDR_W-1:0]   base_q;
    logic [SHIFT_W-1:0]  shift_q;
    logic [BCOUNT_W-1:0] count_q;
    logic                enabled_q;
    logic                used_q [MAX_BUFFERS];
    int                  free_left;
    int                  mismatches;
    pool_reply_t         awaited_replies [$];

    function automatic int live_count();
        return (count_q > MAX_BUFFERS) ? MAX_BUFFERS : int'(count_q);
    endfunction

    function automatic pool_reply_t predict_reply(t_action act, logic [ADDR_W-1:0] faddr);
        pool_reply_t       r;
        int                n;
        int                sh;
        int                slot;
        int                i;
        logic [ADDR_W-1:0] idx;
        r.address = '0;
        r.status  = ST_OK;
        n         = live_count();
        sh        = (shift_q > SHIFT_LIMIT) ? int'(SHIFT_LIMIT) : int'(shift_q);
        slot      = -1;
        if (!enabled_q) begin
            r.status = ST_OFF;
        end else if (act == ACT_ALLOC) begin
            if (free_left != 0) begin
                for (i = 0; i < n; i++) begin
                    if (slot < 0 && !used_q[i]) begin
                        slot = i;
                    end
                end
            end
            if (slot < 0) begin
                r.status = ST_EMPTY;
            end else begin
                used_q[slot] = 1'b1;
                free_left--;
                r.address = base_q + (ADDR_W'(slot) << sh);
            end
        end else if (faddr < base_q) begin
            r.status = ST_BADFREE;
        end else begin
            idx = (faddr - base_q) >> sh;
            if (idx >= ADDR_W'(n)) begin
                r.status = ST_BADFREE;
            end else if (!used_q[idx]) begin
                r.status = ST_BADFREE;
            end else begin
                used_q[idx] = 1'b0;
                free_left++;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        pool_reply_t want;
        pool_reply_t got;
        if (!i_rst_n) begin
            base_q    = '0;
            shift_q   = SHIFT_RESET;
            count_q   = '0;
            enabled_q = 1'b0;
            free_left = 0;
            foreach (used_q[k]) used_q[k] = 1'b0;
            awaited_replies.delete();
        end else begin
            if (rsp.valid && rsp.ready) begin
                got.address = rsp.address;
                got.status  = t_status'(rsp.status);
                if (awaited_replies.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected reply transfer: address %h status %0d",
                                 got.address, got.status);
                    end
                    mismatches++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("reply mismatch: expected address %h status %0d, got address %h status %0d",
                                     want.address, want.status, got.address, got.status);
                        end
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready) begin
                awaited_replies.push_back(predict_reply(t_action'(req.action), req.free_address));
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[REG_SEL_LSB +: 2]))
                    REG_POOL_BASE: begin
                        base_q = pwdata[ADDR_W-1:0];
                    end
                    REG_BUFFER_SHIFT: begin
                        shift_q = pwdata[SHIFT_W-1:0];
                    end
                    REG_BUFFER_COUNT: begin
                        count_q = pwdata[BCOUNT_W-1:0];
                    end
                    REG_ENABLED: begin
                        if (pwdata[0]) begin
                            if (!enabled_q) begin
                                foreach (used_q[k]) used_q[k] = 1'b0;
                                free_left = live_count();
                                enabled_q = 1'b1;
                            end
                        end else begin
                            enabled_q = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_mismatches <= mismatches;
        o_awaited    <= awaited_replies.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bbpa_pkg::*;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  req_valid  = 1'b0;
    t_action               req_action = ACT_ALLOC;
    logic [ADDR_W-1:0]     req_faddr  = '0;
    logic                  rsp_ready  = 1'b0;

    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    mismatches;
    int                    awaited;

    logic [ADDR_W-1:0]     pool_base  = '0;
    int unsigned           pool_shift = 10;
    int unsigned           pool_count = 0;

    bbpa_in_if  req_if ();
    bbpa_out_if rsp_if ();

    assign req_if.valid        = req_valid;
    assign req_if.action       = req_action;
    assign req_if.free_address = req_faddr;
    assign rsp_if.ready        = rsp_ready;

    bitmap_buffer_pool_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    pool_reply_checker reply_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .req          (req_if),
        .rsp          (rsp_if),
        .o_mismatches (mismatches),
        .o_awaited    (awaited)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    task automatic reg_write(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << REG_SEL_LSB;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_POOL_BASE: begin
                pool_base = value[ADDR_W-1:0];
            end
            REG_BUFFER_SHIFT: begin
                pool_shift = value[SHIFT_W-1:0];
            end
            REG_BUFFER_COUNT: begin
                pool_count = value[BCOUNT_W-1:0];
            end
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    // A restart goes through the disabled state so that the usage map is cleared.
    task automatic set_pool(input logic [ADDR_W-1:0] base, input int unsigned shift,
                            input int unsigned count, input bit restart);
        reg_write(REG_POOL_BASE, APB_DATA_W'(base));
        reg_write(REG_BUFFER_SHIFT, APB_DATA_W'(shift));
        reg_write(REG_BUFFER_COUNT, APB_DATA_W'(count));
        if (restart) begin
            reg_write(REG_ENABLED, '0);
        end
        reg_write(REG_ENABLED, APB_DATA_W'(1));
    endtask

    task automatic send_req(input t_action act, input logic [ADDR_W-1:0] faddr);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge i_clk);
        end
        req_valid  <= 1'b1;
        req_action <= act;
        req_faddr  <= faddr;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do @(posedge i_clk); while (awaited != 0);
    endtask

    function automatic logic [ADDR_W-1:0] pick_free_address();
        int unsigned       sh;
        int unsigned       n;
        int unsigned       idx;
        int unsigned       pick;
        logic [ADDR_W-1:0] offset;
        sh     = (pool_shift > SHIFT_LIMIT) ? SHIFT_LIMIT : pool_shift;
        n      = (pool_count > MAX_BUFFERS_DEF) ? MAX_BUFFERS_DEF : pool_count;
        offset = ADDR_W'({$urandom, $urandom}) & ((ADDR_W'(1) << sh) - 1);
        pick   = $urandom_range(99, 0);
        if (pick < 8) begin
            return ADDR_W'({$urandom, $urandom});
        end
        if (pick < 14) begin
            return pool_base - ADDR_W'($urandom_range(4096, 1));
        end
        if (pick < 24 || n == 0) begin
            idx = n + $urandom_range(3, 0);
        end else if (pick < 62) begin
            idx = $urandom_range(((n < 16) ? n : 16) - 1, 0);
        end else begin
            idx = $urandom_range(n - 1, 0);
        end
        return pool_base + (ADDR_W'(idx) << sh) + offset;
    endfunction

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [ADDR_W-1:0] base;
        int unsigned       shift;
        int unsigned       count;
        send_idle_pct = 7;
        recv_idle_pct = 52;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(ACT_ALLOC, '0);
        send_req(ACT_FREE, '1);
        drain();

        base = 48'h0000_1234_5000;
        set_pool(base, 12, 4, 1'b1);
        repeat (5) send_req(ACT_ALLOC, ADDR_W'({$urandom, $urandom}));
        send_req(ACT_FREE, base + (ADDR_W'(2) << 12) + 48'hABC);
        send_req(ACT_FREE, base + (ADDR_W'(2) << 12));
        send_req(ACT_FREE, base - 1);
        send_req(ACT_FREE, base + (ADDR_W'(4) << 12));
        send_req(ACT_ALLOC, '0);
        drain();

        // Shrinking the pool while enabled does not restart it; buffers above the new count stay marked used.
        reg_write(REG_BUFFER_COUNT, APB_DATA_W'(2));
        reg_write(REG_ENABLED, APB_DATA_W'(1));
        send_req(ACT_FREE, base);
        send_req(ACT_ALLOC, '0);
        send_req(ACT_ALLOC, '0);
        drain();

        reg_write(REG_ENABLED, '0);
        send_req(ACT_ALLOC, '0);
        send_req(ACT_FREE, base);
        drain();

        set_pool('1, 31, 511, 1'b0);
        send_req(ACT_ALLOC, '0);
        send_req(ACT_ALLOC, '1);
        send_req(ACT_FREE, 48'h0000_000F_FFFF);
        send_req(ACT_FREE, '1);
        drain();

        set_pool('0, 0, 0, 1'b1);
        send_req(ACT_ALLOC, '0);
        send_req(ACT_FREE, '0);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            send_idle_pct = (ph < 3) ? 7 : ((ph < 6) ? 52 : 0);
            recv_idle_pct = (ph < 3) ? 52 : ((ph < 6) ? 7 : 0);
            base  = (ph == 2) ? '1 : ((ph == 4) ? '0 : ADDR_W'({$urandom, $urandom}));
            shift = (ph == 3) ? 0 : ((ph == 5) ? 31 : $urandom_range(20, 0));
            count = (ph == 1) ? 256 : ((ph == 7) ? 511 : ((ph == 6) ? 1 : $urandom_range(24, 1)));
            set_pool(base, shift, count, (ph % 4) != 3);
            repeat (110) begin
                if ($urandom_range(99, 0) < 55) begin
                    send_req(ACT_ALLOC, ADDR_W'({$urandom, $urandom}));
                end else begin
                    send_req(ACT_FREE, pick_free_address());
                end
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && awaited == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/bbpa_pkg.sv
design/bbpa_in_if.sv
design/bbpa_out_if.sv
design/bbpa_cfg.sv
design/bbpa_core.sv
design/bitmap_buffer_pool_allocator.sv
tb/sv/pool_reply_checker.sv
tb/sv/tb.sv
